FILE: src/clap_pkg.sv
// Shared types, character codes and name tables for the command line parser.
// No dependencies; clap_parser, clap_res_fifo and the core import this package.
`default_nettype none

package clap_pkg;

  localparam int NUM_CAND  = 6;
  localparam int NAME_W    = 8;
  localparam int VAL_W     = 64;
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_X_LO  = "x";
  localparam logic [7:0] CH_X_UP  = "X";

  localparam logic [NUM_CAND-1:0] NAME_ALL = '1;

  // Candidate names: file, filec, addr, value, size, en (padded with NUL)
  localparam logic [7:0] CAND_TEXT [NUM_CAND][NAME_W] = '{
    '{"f", "i", "l", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"f", "i", "l", "e", "c", CH_NUL, CH_NUL, CH_NUL},
    '{"a", "d", "d", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"v", "a", "l", "u", "e", CH_NUL, CH_NUL, CH_NUL},
    '{"s", "i", "z", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
    '{"e", "n", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
  };
  localparam logic [2:0] CAND_LEN [NUM_CAND] = '{3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd2};
  localparam logic       CAND_HAS_SLOT [NUM_CAND] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  localparam logic [1:0] CAND_SLOT [NUM_CAND] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3};

  typedef struct packed {
    logic             kind;
    logic [7:0]       cmd_char;
    logic             status;
    logic             unknown_name;
    logic [VAL_W-1:0] addr_value;
    logic [VAL_W-1:0] data_value;
    logic [VAL_W-1:0] size_value;
    logic [VAL_W-1:0] enable_value;
  } clap_res_t;

  // Up to two result items per accepted byte, d0 first
  typedef struct packed {
    logic [1:0] cnt;
    clap_res_t  d0;
    clap_res_t  d1;
  } clap_push_t;

  function automatic logic is_sp(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  // {ok, digit}: hex letters count 10..15 in either base
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if ((c >= "0") && (c <= "9")) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"))) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [NUM_CAND-1:0] name_feed(input logic [NUM_CAND-1:0] match,
                                                    input logic [2:0] pos,
                                                    input logic [7:0] c);
    logic [NUM_CAND-1:0] m;
    m = match;
    for (int k = 0; k < NUM_CAND; k++) begin
      if (match[k] && ((pos >= CAND_LEN[k]) || (CAND_TEXT[k][pos] != c))) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  // {hit, slot}: a complete name that owns a slot below num_args
  function automatic logic [2:0] commit_hit(input logic [NUM_CAND-1:0] match,
                                            input logic [2:0] pos,
                                            input int num_args);
    logic [2:0] r;
    r = '0;
    for (int k = 0; k < NUM_CAND; k++) begin
      if (match[k] && (pos == CAND_LEN[k]) && CAND_HAS_SLOT[k] &&
          (int'(CAND_SLOT[k]) < num_args)) begin
        r = {1'b1, CAND_SLOT[k]};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/clap_in_if.sv
// Input channel of the command line parser: one byte and its end-of-line mark per item.
// No dependencies.
`default_nettype none

interface clap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_mark;

  modport source (output valid, output char_byte, output end_mark, input ready);
  modport sink (input valid, input char_byte, input end_mark, output ready);
endinterface

`default_nettype wire

FILE: src/clap_out_if.sv
// Result channel of the command line parser: echoed command bytes and line summaries.
// No dependencies.
`default_nettype none

interface clap_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  cmd_char;
  logic        status;
  logic        unknown_name;
  logic [63:0] addr_value;
  logic [63:0] data_value;
  logic [63:0] size_value;
  logic [63:0] enable_value;

  modport source (output valid, output kind, output cmd_char, output status,
                  output unknown_name, output addr_value, output data_value,
                  output size_value, output enable_value, input ready);
  modport sink (input valid, input kind, input cmd_char, input status,
                input unknown_name, input addr_value, input data_value,
                input size_value, input enable_value, output ready);
endinterface

`default_nettype wire

FILE: src/clap_parser.sv
// Per-line parse state and the combinational byte step of the command line parser.
// Depends on clap_pkg; feeds result items to clap_res_fifo.
`default_nettype none

module clap_parser #(
  parameter int NUM_ARGS = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step_en,
  input  wire  [7:0]          char_byte,
  input  wire                 end_mark,
  output clap_pkg::clap_push_t push
);
  import clap_pkg::*;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_GAP1   = 3'd2;
  localparam logic [2:0] PH_NAME   = 3'd3;
  localparam logic [2:0] PH_VSTART = 3'd4;
  localparam logic [2:0] PH_VALUE  = 3'd5;
  localparam logic [2:0] PH_GAP2   = 3'd6;
  localparam logic [2:0] PH_STOP   = 3'd7;

  logic [2:0]          phase_r, phase_nxt;
  logic [NUM_CAND-1:0] match_r, match_nxt;
  logic [2:0]          npos_r, npos_nxt;
  logic [VAL_W-1:0]    acc_r, acc_nxt;
  logic                hex_r, hex_nxt;
  logic                stop_r, stop_nxt;
  logic [1:0]          vpos_r, vpos_nxt;
  logic [VAL_W-1:0]    args_r [4];
  logic [VAL_W-1:0]    args_nxt [4];
  logic                err_r, err_nxt;
  logic                unk_r, unk_nxt;

  // value digit step on the registered value state
  logic [4:0]       dig;
  logic [VAL_W-1:0] feed_acc;
  logic             feed_hex;
  logic             feed_stop;
  logic [1:0]       feed_vpos;

  always_comb begin
    dig       = digit_of(char_byte);
    feed_acc  = acc_r;
    feed_hex  = hex_r;
    feed_stop = stop_r;
    if ((vpos_r == 2'd1) && !stop_r && !hex_r && (acc_r == '0) &&
        ((char_byte == CH_X_LO) || (char_byte == CH_X_UP))) begin
      feed_hex = 1'b1;
    end else if (!stop_r) begin
      if (dig[4]) begin
        feed_acc = (hex_r ? (acc_r << 4) : ((acc_r << 3) + (acc_r << 1))) +
                   {{(VAL_W-4){1'b0}}, dig[3:0]};
      end else begin
        feed_stop = 1'b1;
      end
    end
    feed_vpos = (vpos_r == 2'd3) ? vpos_r : vpos_r + 2'd1;
  end

  logic [2:0] hit_mid, hit_end;
  logic       line_end;
  logic       echo;

  always_comb begin
    phase_nxt = phase_r;
    match_nxt = match_r;
    npos_nxt  = npos_r;
    acc_nxt   = acc_r;
    hex_nxt   = hex_r;
    stop_nxt  = stop_r;
    vpos_nxt  = vpos_r;
    args_nxt  = args_r;
    err_nxt   = err_r;
    unk_nxt   = unk_r;
    echo      = 1'b0;
    hit_mid   = commit_hit(match_r, npos_r, NUM_ARGS);
    hit_end   = '0;
    line_end  = step_en && ((char_byte == CH_NUL) || end_mark);
    push      = '0;

    if (step_en && (char_byte != CH_NUL)) begin
      case (phase_r)
        PH_LEAD: begin
          if (!is_sp(char_byte)) begin
            phase_nxt = PH_CMD;
            echo      = 1'b1;
          end
        end
        PH_CMD: begin
          if (is_sp(char_byte)) begin
            phase_nxt = PH_GAP1;
          end else begin
            echo = 1'b1;
          end
        end
        PH_GAP1, PH_GAP2: begin
          if ((phase_r == PH_GAP1) ? !is_sp(char_byte) : !is_blank(char_byte)) begin
            match_nxt = NAME_ALL;
            npos_nxt  = '0;
            if (char_byte == CH_EQ) begin
              acc_nxt   = '0;
              hex_nxt   = 1'b0;
              stop_nxt  = 1'b0;
              vpos_nxt  = '0;
              phase_nxt = PH_VSTART;
            end else begin
              match_nxt = name_feed(NAME_ALL, 3'd0, char_byte);
              npos_nxt  = 3'd1;
              phase_nxt = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (char_byte == CH_EQ) begin
            acc_nxt   = '0;
            hex_nxt   = 1'b0;
            stop_nxt  = 1'b0;
            vpos_nxt  = '0;
            phase_nxt = PH_VSTART;
          end else begin
            match_nxt = name_feed(match_r, npos_r, char_byte);
            npos_nxt  = (npos_r == 3'd7) ? npos_r : npos_r + 3'd1;
          end
        end
        PH_VSTART, PH_VALUE: begin
          if (is_blank(char_byte)) begin
            if (phase_r == PH_VSTART) begin
              err_nxt   = 1'b1;
              phase_nxt = PH_STOP;
            end else if (hit_mid[2]) begin
              args_nxt[hit_mid[1:0]] = acc_r;
              phase_nxt = PH_GAP2;
            end else begin
              unk_nxt   = 1'b1;
              phase_nxt = PH_STOP;
            end
          end else begin
            acc_nxt   = feed_acc;
            hex_nxt   = feed_hex;
            stop_nxt  = feed_stop;
            vpos_nxt  = feed_vpos;
            phase_nxt = PH_VALUE;
          end
        end
        default: begin
        end
      endcase
    end

    if (echo) begin
      push.d0.cmd_char = char_byte;
      push.cnt         = 2'd1;
    end

    if (line_end) begin
      // close an open name or value
      hit_end = commit_hit(match_nxt, npos_nxt, NUM_ARGS);
      if (phase_nxt == PH_NAME) begin
        err_nxt = 1'b1;
      end else if ((phase_nxt == PH_VSTART) || (phase_nxt == PH_VALUE)) begin
        if (hit_end[2]) begin
          args_nxt[hit_end[1:0]] = acc_nxt;
        end else begin
          unk_nxt = 1'b1;
        end
      end
      if (echo) begin
        push.d1.kind         = 1'b1;
        push.d1.status       = err_nxt;
        push.d1.unknown_name = unk_nxt;
        push.d1.addr_value   = args_nxt[0];
        push.d1.data_value   = args_nxt[1];
        push.d1.size_value   = args_nxt[2];
        push.d1.enable_value = args_nxt[3];
        push.cnt             = 2'd2;
      end else begin
        push.d0.kind         = 1'b1;
        push.d0.status       = err_nxt;
        push.d0.unknown_name = unk_nxt;
        push.d0.addr_value   = args_nxt[0];
        push.d0.data_value   = args_nxt[1];
        push.d0.size_value   = args_nxt[2];
        push.d0.enable_value = args_nxt[3];
        push.cnt             = 2'd1;
      end
      // drop the whole line state once the summary is out
      phase_nxt = PH_LEAD;
      match_nxt = NAME_ALL;
      npos_nxt  = '0;
      acc_nxt   = '0;
      hex_nxt   = 1'b0;
      stop_nxt  = 1'b0;
      vpos_nxt  = '0;
      args_nxt  = '{default: '0};
      err_nxt   = 1'b0;
      unk_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      match_r <= NAME_ALL;
      npos_r  <= '0;
      acc_r   <= '0;
      hex_r   <= 1'b0;
      stop_r  <= 1'b0;
      vpos_r  <= '0;
      args_r  <= '{default: '0};
      err_r   <= 1'b0;
      unk_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      match_r <= match_nxt;
      npos_r  <= npos_nxt;
      acc_r   <= acc_nxt;
      hex_r   <= hex_nxt;
      stop_r  <= stop_nxt;
      vpos_r  <= vpos_nxt;
      args_r  <= args_nxt;
      err_r   <= err_nxt;
      unk_r   <= unk_nxt;
    end
  end

`ifndef SYNTHESIS
  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    line_end |=> (phase_r == PH_LEAD) && (npos_r == 3'd0) && (acc_r == '0) &&
                 (args_r[0] == '0) && (args_r[1] == '0) && (args_r[2] == '0) &&
                 (args_r[3] == '0) && !err_r && !unk_r)
    else $error("line state not cleared after summary");
  a_echo_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0 && !push.d0.kind) |-> (phase_r == PH_LEAD) || (phase_r == PH_CMD))
    else $error("command byte echoed outside the command word");
  a_flag_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r || unk_r) |-> (phase_r == PH_STOP))
    else $error("error or unknown name without stopped parse");
`endif

endmodule

`default_nettype wire

FILE: src/clap_res_fifo.sv
// Four-entry result queue: takes up to two items per cycle, hands out one while the reader is ready.
// Depends on clap_pkg.
`default_nettype none

module clap_res_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire clap_pkg::clap_push_t push,
  output logic                 room,
  output logic                 rd_valid,
  input  wire                  rd_ready,
  output clap_pkg::clap_res_t  rd_data
);
  import clap_pkg::*;

  clap_res_t            mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 pop;

  assign room     = (cnt_r <= RES_CNT_W'(RES_DEPTH - 2));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    cnt_nxt    = cnt_r + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.d0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + RES_PTR_W'(1)] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (4'(cnt_r) + 4'(push.cnt)) <= 4'(RES_DEPTH))
    else $error("result queue overflow");
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (push.cnt == 2'd0)) |=> (cnt_r == $past(cnt_r) - RES_CNT_W'(1)))
    else $error("result queue count wrong after pop");
`endif

endmodule

`default_nettype wire

FILE: src/command_line_arg_parser_core.sv
// Command line parser: takes one byte per cycle, at full rate, as long as the result
// queue has two free entries; each byte is parsed in the cycle it is accepted, and its
// results (a command word echo, the line summary, or both for a final command byte) are
// queued in a four-entry result queue and appear on the output from the next cycle on,
// one per cycle unless stalled. Input ready drops whenever fewer than two queue entries
// are free: while the result side stalls, or when bytes that each give two results follow
// back to back faster than the output drains them. No clearing pass is needed after reset.
`default_nettype none

module command_line_arg_parser_core #(
  parameter int NUM_ARGS = 4
) (
  input  wire        clk,
  input  wire        rst_n,
  clap_in_if.sink    in_chan,
  clap_out_if.source out_chan
);
  import clap_pkg::*;

  clap_push_t push;
  clap_res_t  rd_data;
  logic       room;
  logic       step_en;

  assign in_chan.ready = room;
  assign step_en       = in_chan.valid && room;

  clap_parser #(
    .NUM_ARGS (NUM_ARGS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .char_byte (in_chan.char_byte),
    .end_mark  (in_chan.end_mark),
    .push      (push)
  );

  clap_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .rd_valid (out_chan.valid),
    .rd_ready (out_chan.ready),
    .rd_data  (rd_data)
  );

  assign out_chan.kind         = rd_data.kind;
  assign out_chan.cmd_char     = rd_data.cmd_char;
  assign out_chan.status       = rd_data.status;
  assign out_chan.unknown_name = rd_data.unknown_name;
  assign out_chan.addr_value   = rd_data.addr_value;
  assign out_chan.data_value   = rd_data.data_value;
  assign out_chan.size_value   = rd_data.size_value;
  assign out_chan.enable_value = rd_data.enable_value;

endmodule

`default_nettype wire
